### design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the cube vertex projection design.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Antecedent implies consequent in the next cycle.
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### design/cvp_pkg.sv
// ----------------------------------------------------------------------------
// cvp_pkg
// Types, widths and constants of the cube vertex projection block.
// ----------------------------------------------------------------------------
`default_nettype none

package cvp_pkg;

    localparam int W_W      = 25;  // world value, 8 fraction bits
    localparam int OFF_W    = 22;  // edge offset per component
    localparam int R_W      = 37;  // reciprocal, 16 fraction bits
    localparam int R_LO_W   = 18;  // low slice of the reciprocal
    localparam int MA_W     = 26;  // shared multiplier operand a
    localparam int MB_W     = 20;  // shared multiplier operand b
    localparam int P_W      = MA_W + MB_W;
    localparam int ACC_W    = 64;
    localparam int SCALE_SH = 24;
    localparam int ROT_SH   = 14;
    localparam int OFF_SH   = 5;
    localparam int WORLD_SH = 8;

    localparam logic [2:0] REG_EDGE  = 3'd0;
    localparam logic [2:0] REG_ORG_X = 3'd1;
    localparam logic [2:0] REG_ORG_Y = 3'd2;
    localparam logic [2:0] REG_ORG_Z = 3'd3;
    localparam logic [2:0] REG_CEN_X = 3'd4;
    localparam logic [2:0] REG_CEN_Y = 3'd5;
    localparam logic [2:0] REG_COS   = 3'd6;
    localparam logic [2:0] REG_SIN   = 3'd7;

    localparam logic REQ_DRAW = 1'b0;
    localparam logic REQ_LOAD = 1'b1;

    localparam logic [10:0] EDGE_RST  = 11'd100;
    localparam logic [11:0] CEN_X_RST = 12'd400;
    localparam logic [11:0] CEN_Y_RST = 12'd300;
    localparam logic signed [15:0] COS_RST = 16'sd16384;
    localparam logic signed [15:0] DIR_RST = -16'sd8192;
    localparam logic [R_W-1:0] RECIP_ONE = R_W'(65536);
    localparam logic signed [ACC_W-1:0] ROT_HALF  = ACC_W'(8192);
    localparam logic signed [ACC_W-1:0] TRUNC_ADJ = ACC_W'(16777215);
    localparam logic [2:0] LAST_VTX = 3'd7;

    typedef enum logic [3:0] {
        S_IDLE, S_OFF, S_W, S_DIV, S_DIVW, S_MUL, S_SCR, S_OUT, S_WAIT, S_ROT
    } t_state;

    typedef struct packed {
        logic               req_type;
        logic signed [15:0] load_dx;
        logic signed [15:0] load_dy;
        logic signed [15:0] load_dz;
    } t_req;

    typedef struct packed {
        logic [2:0]         vertex_index;
        logic signed [15:0] screen_x;
        logic signed [15:0] screen_y;
        logic               last_vertex;
    } t_vtx;

    function automatic logic signed [15:0] sat16(input logic signed [ACC_W-1:0] v);
        logic signed [15:0] res;
        if (v > ACC_W'(32767)) begin
            res = 16'sh7fff;
        end else if (v < -ACC_W'(32768)) begin
            res = 16'sh8000;
        end else begin
            res = v[15:0];
        end
        return res;
    endfunction

    // Divide by 2^24 toward zero, then saturate.
    function automatic logic signed [15:0] screen_val(input logic signed [ACC_W-1:0] d);
        logic signed [ACC_W-1:0] adj;
        adj = d[ACC_W-1] ? (d + TRUNC_ADJ) : d;
        return sat16(adj >>> SCALE_SH);
    endfunction

    // Round to nearest with ties up, then saturate.
    function automatic logic signed [15:0] rot_round(input logic signed [ACC_W-1:0] a);
        logic signed [ACC_W-1:0] t;
        t = a + ROT_HALF;
        return sat16(t >>> ROT_SH);
    endfunction

endpackage

`default_nettype wire

### design/cvp_stream_if.sv
// ----------------------------------------------------------------------------
// cvp_stream_if
// Valid/ready channel carrying one packed payload per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface cvp_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

### design/cvp_div.sv
// ----------------------------------------------------------------------------
// cvp_div
// Restoring divider producing one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module cvp_div
    import cvp_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [R_W-1:0]   i_num,
    input  wire logic [W_W-1:0]   i_den,
    output logic                  o_busy,
    output logic                  o_done,
    output logic [R_W-1:0]        o_quot
);

    localparam int CNT_W = $clog2(R_W + 1);

    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [R_W-1:0]   r_q;
    logic [W_W:0]     r_rem;
    logic [W_W-1:0]   r_den;
    logic [W_W:0]     n_sh;
    logic             n_ge;

    always_comb begin
        n_sh = {r_rem[W_W-1:0], r_q[R_W-1]};
        n_ge = (n_sh >= {1'b0, r_den});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(R_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= n_ge ? (n_sh - {1'b0, r_den}) : n_sh;
            r_q   <= {r_q[R_W-2:0], n_ge};
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quot = r_q;

    `ASSERT_IMP(a_start_idle, i_clk, i_rst_n, i_start, !r_busy)

endmodule

`default_nettype wire

### design/cube_vertex_projection.sv
// Draw request: after the accepting beat come the offset phase, the eight vertices and the
// rotation; each vertex passes through the bit-serial divider, and skips it when its depth
// is zero. No new request is taken until the draw, output stalls included, is done.
// Load request: the block stays idle, so the next request can be taken the cycle after.
// Synchronous active-low reset: configuration registers to reset values, vector to -1.0 each.
// ----------------------------------------------------------------------------
// cube_vertex_projection
// Projects the eight cube vertices through one shared multiplier and divider,
// then rotates the direction vector about Y and X.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module cube_vertex_projection
    import cvp_pkg::*;
#(
    parameter int FIELD_OF_VIEW = 256
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    cvp_stream_if.sink       i_req,
    cvp_stream_if.source     o_vtx,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    t_state r_state, n_state;
    logic [3:0] r_cnt;
    logic [2:0] r_k;

    logic [10:0]        r_edge;
    logic signed [15:0] r_org_x, r_org_y, r_org_z;
    logic [11:0]        r_cen_x, r_cen_y;
    logic signed [15:0] r_cos, r_sin;
    logic signed [15:0] r_dx, r_dy, r_dz;
    logic signed [15:0] r_tx, r_ty, r_tz;

    logic signed [OFF_W-1:0] r_off_x, r_off_y, r_off_z;
    logic signed [W_W-1:0]   r_wx, r_wy, r_wz;
    logic [R_W-1:0]          r_recip;
    logic signed [P_W-1:0]   r_prod;
    logic signed [ACC_W-1:0] r_acc, r_px, r_py, r_px0, r_py0, r_dfx, r_dfy;
    t_vtx                    r_out;
    logic                    r_ovalid;

    logic signed [MA_W-1:0]  mul_a;
    logic signed [MB_W-1:0]  mul_b;
    logic signed [ACC_W-1:0] prod_ext, cen_x_s, cen_y_s;
    logic signed [15:0]      rot_res;
    logic                    wr_en, req_acc, div_start, div_busy, div_done;
    logic                    is_draw, is_load, vtx_last_ok;
    logic [R_W-1:0]          div_quot;
    logic [W_W-1:0]          wz_mag;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign req_acc = i_req.valid && i_req.ready;
    assign is_draw = (i_req.data.req_type == REQ_DRAW);
    assign is_load = (i_req.data.req_type == REQ_LOAD);
    assign i_req.ready = (r_state == S_IDLE);
    assign o_vtx.valid = r_ovalid;
    assign o_vtx.data  = r_out;
    assign vtx_last_ok = o_vtx.data.last_vertex == (o_vtx.data.vertex_index == LAST_VTX);

    assign prod_ext = ACC_W'(r_prod);
    assign cen_x_s  = ACC_W'($signed({1'b0, r_cen_x})) <<< SCALE_SH;
    assign cen_y_s  = ACC_W'($signed({1'b0, r_cen_y})) <<< SCALE_SH;
    assign rot_res  = rot_round(r_acc);
    assign wz_mag   = r_wz[W_W-1] ? W_W'(-r_wz) : W_W'(r_wz);
    assign div_start = (r_state == S_DIV) && (r_wz != '0);

    always_comb begin
        case (paddr[4:2])
            REG_EDGE:  prdata = {21'b0, r_edge};
            REG_ORG_X: prdata = {16'b0, r_org_x};
            REG_ORG_Y: prdata = {16'b0, r_org_y};
            REG_ORG_Z: prdata = {16'b0, r_org_z};
            REG_CEN_X: prdata = {20'b0, r_cen_x};
            REG_CEN_Y: prdata = {20'b0, r_cen_y};
            REG_COS:   prdata = {16'b0, r_cos};
            REG_SIN:   prdata = {16'b0, r_sin};
            default:   prdata = '0;
        endcase
    end

    // Operand selection for the shared multiplier.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_state)
            S_OFF: begin
                mul_b = MB_W'($signed({1'b0, r_edge}));
                case (r_cnt[1:0])
                    2'd0:    mul_a = MA_W'(r_dx);
                    2'd1:    mul_a = MA_W'(r_dy);
                    default: mul_a = MA_W'(r_dz);
                endcase
            end
            S_MUL: begin
                mul_a = r_cnt[1] ? MA_W'(r_wy) : MA_W'(r_wx);
                mul_b = r_cnt[0] ? MB_W'($signed({1'b0, r_recip[R_W-1:R_LO_W]}))
                                 : MB_W'($signed({2'b0, r_recip[R_LO_W-1:0]}));
            end
            S_ROT: begin
                // First product of each pair uses cosine, the second sine.
                mul_b = r_cnt[0] ? MB_W'(r_sin) : MB_W'(r_cos);
                case (r_cnt[3:0])
                    4'd0:    mul_a = MA_W'(r_dx);
                    4'd1:    mul_a = MA_W'(r_dz);
                    4'd4:    mul_a = MA_W'(r_dz);
                    4'd5:    mul_a = MA_W'(r_dx);
                    4'd8:    mul_a = MA_W'(r_dy);
                    4'd9:    mul_a = MA_W'(r_tz);
                    4'd12:   mul_a = MA_W'(r_tz);
                    4'd13:   mul_a = MA_W'(r_dy);
                    default: mul_a = '0;
                endcase
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (req_acc && is_draw) n_state = S_OFF;
            S_OFF:  if (r_cnt == 4'd3) n_state = S_W;
            S_W:    n_state = S_DIV;
            S_DIV:  n_state = (r_wz == '0) ? S_MUL : S_DIVW;
            S_DIVW: if (div_done) n_state = S_MUL;
            S_MUL:  if (r_cnt == 4'd4) n_state = S_SCR;
            S_SCR:  n_state = S_OUT;
            S_OUT:  n_state = S_WAIT;
            S_WAIT: begin
                if (o_vtx.ready) begin
                    n_state = (r_k == LAST_VTX) ? S_ROT : S_W;
                end
            end
            S_ROT:  if (r_cnt == 4'd15) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Control state, configuration and the direction vector.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt    <= '0;
            r_k      <= '0;
            r_ovalid <= 1'b0;
            r_edge   <= EDGE_RST;
            r_org_x  <= '0;
            r_org_y  <= '0;
            r_org_z  <= '0;
            r_cen_x  <= CEN_X_RST;
            r_cen_y  <= CEN_Y_RST;
            r_cos    <= COS_RST;
            r_sin    <= '0;
            r_dx     <= DIR_RST;
            r_dy     <= DIR_RST;
            r_dz     <= DIR_RST;
        end else begin
            if (wr_en) begin
                case (paddr[4:2])
                    REG_EDGE:  r_edge  <= pwdata[10:0];
                    REG_ORG_X: r_org_x <= pwdata[15:0];
                    REG_ORG_Y: r_org_y <= pwdata[15:0];
                    REG_ORG_Z: r_org_z <= pwdata[15:0];
                    REG_CEN_X: r_cen_x <= pwdata[11:0];
                    REG_CEN_Y: r_cen_y <= pwdata[11:0];
                    REG_COS:   r_cos   <= pwdata[15:0];
                    REG_SIN:   r_sin   <= pwdata[15:0];
                    default:   r_sin   <= r_sin;
                endcase
            end
            case (r_state)
                S_IDLE: begin
                    r_cnt <= '0;
                    r_k   <= '0;
                    if (req_acc && is_load) begin
                        r_dx <= i_req.data.load_dx;
                        r_dy <= i_req.data.load_dy;
                        r_dz <= i_req.data.load_dz;
                    end
                end
                S_OFF:  r_cnt <= (r_cnt == 4'd3) ? 4'd0 : r_cnt + 1'b1;
                S_MUL:  r_cnt <= (r_cnt == 4'd4) ? 4'd0 : r_cnt + 1'b1;
                S_OUT:  r_ovalid <= 1'b1;
                S_WAIT: begin
                    if (o_vtx.ready) begin
                        r_ovalid <= 1'b0;
                        r_k      <= r_k + 1'b1;
                    end
                end
                S_ROT: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == 4'd15) begin
                        r_dx <= r_tx;
                        r_dy <= r_ty;
                        r_dz <= rot_res;
                    end
                end
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    // Datapath payload.
    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
        case (r_state)
            S_OFF: begin
                case (r_cnt)
                    4'd1:    r_off_x <= OFF_W'(r_prod >>> OFF_SH);
                    4'd2:    r_off_y <= OFF_W'(r_prod >>> OFF_SH);
                    4'd3:    r_off_z <= OFF_W'(r_prod >>> OFF_SH);
                    default: r_off_x <= r_off_x;
                endcase
            end
            S_W: begin
                r_wx <= (W_W'(r_org_x) <<< WORLD_SH) + (r_k[0] ? W_W'(r_off_x) : '0);
                r_wy <= (W_W'(r_org_y) <<< WORLD_SH) + (r_k[1] ? W_W'(r_off_y) : '0);
                r_wz <= (W_W'(r_org_z) <<< WORLD_SH) + (r_k[2] ? W_W'(r_off_z) : '0);
            end
            S_DIV:  if (r_wz == '0) r_recip <= RECIP_ONE;
            S_DIVW: if (div_done) r_recip <= div_quot;
            S_MUL: begin
                case (r_cnt)
                    4'd1:    r_acc <= prod_ext;
                    4'd2:    r_px  <= r_acc + (prod_ext <<< R_LO_W);
                    4'd3:    r_acc <= prod_ext;
                    4'd4:    r_py  <= r_acc + (prod_ext <<< R_LO_W);
                    default: r_acc <= r_acc;
                endcase
            end
            S_SCR: begin
                if (r_k == '0) begin
                    r_px0 <= r_px;
                    r_py0 <= r_py;
                    r_dfx <= cen_x_s;
                    r_dfy <= cen_y_s;
                end else begin
                    r_dfx <= r_px - r_px0 + cen_x_s;
                    r_dfy <= r_py - r_py0 + cen_y_s;
                end
            end
            S_OUT: begin
                r_out.vertex_index <= r_k;
                r_out.screen_x     <= screen_val(r_dfx);
                r_out.screen_y     <= screen_val(r_dfy);
                r_out.last_vertex  <= (r_k == LAST_VTX);
            end
            S_ROT: begin
                case (r_cnt[1:0])
                    2'd1: r_acc <= prod_ext;
                    2'd2: r_acc <= r_cnt[2] ? (r_acc - prod_ext) : (r_acc + prod_ext);
                    2'd3: begin
                        case (r_cnt[3:2])
                            2'd0:    r_tx <= rot_res;
                            2'd1:    r_tz <= rot_res;
                            2'd2:    r_ty <= rot_res;
                            default: r_tx <= r_tx;
                        endcase
                    end
                    default: r_acc <= r_acc;
                endcase
            end
            default: r_acc <= r_acc;
        endcase
    end

    cvp_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (R_W'(FIELD_OF_VIEW) << SCALE_SH),
        .i_den   (wz_mag),
        .o_busy  (div_busy),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    `ASSERT_IMP(a_last_is_seven, i_clk, i_rst_n, o_vtx.valid, vtx_last_ok)
    `ASSERT_IMP(a_no_overlap, i_clk, i_rst_n, o_vtx.valid, !i_req.ready)
    `ASSERT_NXT(a_draw_busy, i_clk, i_rst_n, req_acc && is_draw, !i_req.ready)
    `ASSERT_IMP(a_div_state, i_clk, i_rst_n, div_busy, r_state == S_DIVW)

endmodule

`default_nettype wire

### verif/tb_cube_vertex_projection.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_cube_vertex_projection
// Self-checking bench for the cube vertex projection block. Vector loads and
// frame draws go in through the request channel, while the register port
// changes the cube geometry and the rotation angle between phases. An
// in-bench predictor computes the eight vertices of every frame and the
// rotated vector, and each vertex beat is compared field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_cube_vertex_projection
    import cvp_pkg::*;
();

    localparam int FOV       = 256;
    localparam int MAX_CYC   = 1000000;
    localparam int IDLE_LAST = 60;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [4:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    cvp_stream_if #(.T(t_req)) req_if ();
    cvp_stream_if #(.T(t_vtx)) vtx_if ();

    cube_vertex_projection #(.FIELD_OF_VIEW(FOV)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(req_if.sink), .o_vtx(vtx_if.source),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #2 i_clk = ~i_clk;

    // Predictor state: registers and the direction vector.
    logic [10:0] m_edge;
    logic signed [15:0] m_org [3];
    logic [11:0] m_cen [2];
    logic signed [15:0] m_cos, m_sin;
    logic signed [15:0] m_dir [3];

    t_req req_pending[$];
    t_vtx vtx_expected[$];
    int errors = 0;
    int draws = 0, loads = 0, beats_seen = 0;
    longint cycles = 0;
    bit quiet = 1'b0;          // no random idling
    int stall_left = 0;        // long receiver hold-off
    int rx_idle = 0;           // remaining cycles of a short receiver gap
    bit hold_sender = 1'b0;

    function automatic longint floor_div(longint v, int sh);
        return v >>> sh;
    endfunction

    function automatic longint clamp16(longint v);
        if (v > 32767) return 32767;
        if (v < -32768) return -32768;
        return v;
    endfunction

    function automatic longint rot_nearest(longint acc);
        return clamp16((acc + 8192) >>> 14);
    endfunction

    task automatic project_frame();
        longint w [3];
        longint r, sx, sy, c, s, x, y, z, x1, z1, y2, z2;
        longint px [8];
        longint py [8];
        t_vtx v;
        for (int k = 0; k < 8; k++) begin
            for (int j = 0; j < 3; j++) begin
                w[j] = longint'(m_org[j]) * 256;
                if (k[j])
                    w[j] += floor_div(longint'(m_dir[j]) * longint'(m_edge), 5);
            end
            if (w[2] == 0) r = 65536;
            else r = (longint'(FOV) << 24) / (w[2] < 0 ? -w[2] : w[2]);
            px[k] = w[0] * r;
            py[k] = w[1] * r;
        end
        for (int k = 0; k < 8; k++) begin
            sx = (px[k] - px[0] + (longint'(m_cen[0]) << 24)) / (longint'(1) << 24);
            sy = (py[k] - py[0] + (longint'(m_cen[1]) << 24)) / (longint'(1) << 24);
            v.vertex_index = k[2:0];
            v.screen_x = 16'(clamp16(sx));
            v.screen_y = 16'(clamp16(sy));
            v.last_vertex = (k == 7);
            vtx_expected.push_back(v);
        end
        c = m_cos; s = m_sin; x = m_dir[0]; y = m_dir[1]; z = m_dir[2];
        x1 = rot_nearest(c * x + s * z);
        z1 = rot_nearest(c * z - s * x);
        y2 = rot_nearest(c * y + s * z1);
        z2 = rot_nearest(c * z1 - s * y);
        m_dir[0] = 16'(x1); m_dir[1] = 16'(y2); m_dir[2] = 16'(z2);
    endtask

    task automatic apply_request(t_req q);
        if (q.req_type == REQ_LOAD) begin
            m_dir[0] = q.load_dx; m_dir[1] = q.load_dy; m_dir[2] = q.load_dz;
            loads++;
        end else begin
            project_frame();
            draws++;
        end
    endtask

    // Driver: feeds pending requests with random gaps.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
            req_if.data <= '0;
        end else begin
            if (req_if.valid && req_if.ready) apply_request(req_if.data);
            if (req_if.valid && !req_if.ready) begin
                // hold the offered beat
            end else if (req_pending.size() > 0 && !hold_sender
                         && (quiet || $urandom_range(0, 3) != 0)) begin
                req_if.valid <= 1'b1;
                req_if.data <= req_pending.pop_front();
            end else begin
                req_if.valid <= 1'b0;
                if (!quiet && req_pending.size() > 0)
                    repeat ($urandom_range(0, 2)) @(posedge i_clk);
            end
        end
    end

    // Monitor: compares each vertex beat and drives ready.
    always @(posedge i_clk) begin
        t_vtx got, exp_v;
        cycles++;
        if (!i_rst_n) begin
            vtx_if.ready <= 1'b0;
        end else begin
            if (vtx_if.valid && vtx_if.ready) begin
                got = vtx_if.data;
                beats_seen++;
                if (vtx_expected.size() == 0) begin
                    $display("%0t: unexpected vertex beat %p", $time, got);
                    errors++;
                end else begin
                    exp_v = vtx_expected.pop_front();
                    if (got.vertex_index !== exp_v.vertex_index) begin
                        $display("%0t: vertex_index expected %0d actual %0d", $time,
                                 exp_v.vertex_index, got.vertex_index);
                        errors++;
                    end
                    if (got.screen_x !== exp_v.screen_x) begin
                        $display("%0t: screen_x v%0d expected %0d actual %0d", $time,
                                 exp_v.vertex_index, exp_v.screen_x, got.screen_x);
                        errors++;
                    end
                    if (got.screen_y !== exp_v.screen_y) begin
                        $display("%0t: screen_y v%0d expected %0d actual %0d", $time,
                                 exp_v.vertex_index, exp_v.screen_y, got.screen_y);
                        errors++;
                    end
                    if (got.last_vertex !== exp_v.last_vertex) begin
                        $display("%0t: last_vertex v%0d expected %0d actual %0d", $time,
                                 exp_v.vertex_index, exp_v.last_vertex, got.last_vertex);
                        errors++;
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                vtx_if.ready <= 1'b0;
            end else if (quiet) begin
                vtx_if.ready <= 1'b1;
            end else if (rx_idle > 0) begin
                rx_idle--;
                vtx_if.ready <= 1'b0;
            end else if ($urandom_range(0, 3) == 0) begin
                rx_idle = $urandom_range(0, 2);
                vtx_if.ready <= 1'b0;
            end else begin
                vtx_if.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (cycles > MAX_CYC) begin
            $display("timeout after %0d cycles", cycles);
            $display("end of test: mismatches");
            $finish;
        end
    end

    task automatic reg_write(logic [2:0] idx, logic [31:0] val);
        logic [31:0] exp_rd;
        exp_rd = {16'b0, val[15:0]};
        @(posedge i_clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {idx, 2'b00}; pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        case (idx)
            REG_EDGE: begin
                m_edge = val[10:0];
                exp_rd = {21'b0, val[10:0]};
            end
            REG_ORG_X: m_org[0] = val[15:0];
            REG_ORG_Y: m_org[1] = val[15:0];
            REG_ORG_Z: m_org[2] = val[15:0];
            REG_CEN_X: begin
                m_cen[0] = val[11:0];
                exp_rd = {20'b0, val[11:0]};
            end
            REG_CEN_Y: begin
                m_cen[1] = val[11:0];
                exp_rd = {20'b0, val[11:0]};
            end
            REG_COS:   m_cos = val[15:0];
            REG_SIN:   m_sin = val[15:0];
            default: ;
        endcase
        // The address still points at the register, so read it back.
        #1;
        if (prdata !== exp_rd || pready !== 1'b1) begin
            $display("%0t: register %0d read expected %0h actual %0h", $time,
                     idx, exp_rd, prdata);
            errors++;
        end
    endtask

    task automatic drain();
        while (req_pending.size() > 0 || req_if.valid || vtx_expected.size() > 0)
            @(posedge i_clk);
        repeat (IDLE_LAST) @(posedge i_clk);
    endtask

    function automatic t_req load_req(logic [15:0] dx, logic [15:0] dy, logic [15:0] dz);
        t_req q;
        q.req_type = REQ_LOAD; q.load_dx = dx; q.load_dy = dy; q.load_dz = dz;
        return q;
    endfunction

    function automatic t_req draw_req();
        t_req q;
        q.req_type = REQ_DRAW;
        q.load_dx = 16'($urandom); q.load_dy = 16'($urandom); q.load_dz = 16'($urandom);
        return q;
    endfunction

    // Mostly small vectors, sometimes the extremes.
    function automatic logic [15:0] rand_dir();
        if ($urandom_range(0, 7) == 0) return 16'($urandom);
        return 16'($signed($urandom_range(0, 32768)) - 16384);
    endfunction

    task automatic random_phase(int n);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 3) == 0)
                req_pending.push_back(load_req(rand_dir(), rand_dir(), rand_dir()));
            else
                req_pending.push_back(draw_req());
        end
    endtask

    task automatic random_config();
        reg_write(REG_EDGE, $urandom_range(0, 3) == 0 ? $urandom_range(0, 2047)
                                                       : $urandom_range(0, 1024));
        reg_write(REG_ORG_X, $urandom_range(0, 1) ? $urandom : $urandom_range(0, 400) - 200);
        reg_write(REG_ORG_Y, $urandom_range(0, 1) ? $urandom : $urandom_range(0, 400) - 200);
        reg_write(REG_ORG_Z, $urandom_range(0, 1) ? $urandom : $urandom_range(0, 400) - 200);
        reg_write(REG_CEN_X, $urandom_range(0, 4095));
        reg_write(REG_CEN_Y, $urandom_range(0, 4095));
        reg_write(REG_COS, $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 32768) - 16384);
        reg_write(REG_SIN, $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 32768) - 16384);
    endtask

    initial begin
        m_edge = EDGE_RST; m_org[0] = '0; m_org[1] = '0; m_org[2] = '0;
        m_cen[0] = CEN_X_RST; m_cen[1] = CEN_Y_RST; m_cos = COS_RST; m_sin = '0;
        m_dir[0] = DIR_RST; m_dir[1] = DIR_RST; m_dir[2] = DIR_RST;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: reset settings, zero depth (origin z zero), extreme vectors.
        req_pending.push_back(draw_req());
        req_pending.push_back(load_req(16'h7fff, 16'h8000, 16'h0000));
        req_pending.push_back(draw_req());
        req_pending.push_back(load_req(16'h8000, 16'h7fff, 16'hffff));
        req_pending.push_back(draw_req());
        drain();
        // Extreme geometry, large edge and unnormalized angle so values saturate.
        reg_write(REG_EDGE, 32'd2047);
        reg_write(REG_ORG_X, 32'h7fff);
        reg_write(REG_ORG_Y, 32'hffff8000);
        reg_write(REG_ORG_Z, 32'h0001);
        reg_write(REG_CEN_X, 32'd4095);
        reg_write(REG_CEN_Y, 32'd0);
        reg_write(REG_COS, 32'h7fff);
        reg_write(REG_SIN, 32'h8000);
        req_pending.push_back(load_req(16'h7fff, 16'h7fff, 16'h7fff));
        for (int i = 0; i < 3; i++) req_pending.push_back(draw_req());
        drain();
        reg_write(REG_EDGE, 32'd0);
        reg_write(REG_ORG_Z, 32'hffff8000);
        reg_write(REG_COS, 32'hffffc000);
        reg_write(REG_SIN, 32'h4000);
        req_pending.push_back(draw_req());
        req_pending.push_back(load_req(16'h0000, 16'h0000, 16'h0000));
        req_pending.push_back(draw_req());
        drain();
        reg_write(REG_EDGE, 32'd1024);
        reg_write(REG_ORG_Z, 32'd0);
        req_pending.push_back(draw_req());
        req_pending.push_back(draw_req());
        drain();

        // Random phases with a new setting each time.
        for (int p = 0; p < 6; p++) begin
            random_config();
            random_phase(50);
            if (p == 2) begin
                // Long receiver hold-off while requests keep coming.
                stall_left = 400;
            end
            drain();
        end

        // Sender pause: wait for every vertex, then resume with no idling.
        hold_sender = 1'b1;
        drain();
        hold_sender = 1'b0;
        quiet = 1'b1;
        random_config();
        random_phase(40);
        drain();

        $display("covered %0d draws and %0d vector loads, %0d vertex beats checked",
                 draws, loads, beats_seen);
        $display("register settings changed between phases, extreme values included");
        if (errors == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end
endmodule

`default_nettype wire

### cube_vertex_projection.f
+incdir+design
design/cvp_pkg.sv
design/cvp_stream_if.sv
design/cvp_div.sv
design/cube_vertex_projection.sv
verif/tb_cube_vertex_projection.sv
